/* hdl/running_mean_deviation_stats_defines.svh */
// Assertion helpers shared by the statistics block
`ifndef RUNNING_MEAN_DEVIATION_STATS_DEFINES_SVH
`define RUNNING_MEAN_DEVIATION_STATS_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define RMDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on clk, off during rst
`define RMDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/rmds_pkg.sv */
`timescale 1ns / 1ps
package rmds_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int WIDE            = 128;
  localparam int CFG_W           = 48;

  localparam logic [1:0] REG_SEED_COUNT     = 2'd0;
  localparam logic [1:0] REG_SEED_MEAN      = 2'd1;
  localparam logic [1:0] REG_SEED_HARMONIC  = 2'd2;
  localparam logic [1:0] REG_SEED_DEVIATION = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_DIV,
    S_DEV_SQ,
    S_MEAN_SQ,
    S_SCALE_W,
    S_MS_DIV,
    S_RMS_ROOT,
    S_NEW_SQ,
    S_DEV_ROOT,
    S_HARM_T,
    S_HARM_DEN,
    S_HM_MUL,
    S_HN_MUL,
    S_HARM_DIV,
    S_DONE
  } state_t;

endpackage

/* hdl/rmds_arith.sv */
`timescale 1ns / 1ps
// Shared iterative unit: shift-add multiply (64 steps), restoring divide
// (128 steps), digit-by-digit square root (64 steps).
module rmds_arith
  import rmds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  arith_req_t       req,
  input  logic [WIDE-1:0]  opnd_a,
  input  logic [WIDE-1:0]  opnd_b,
  output arith_stat_t      stat,
  output logic [WIDE-1:0]  result
);

  logic            busy;
  logic            done;
  arith_op_t       op_r;
  logic [6:0]      cnt;
  logic [WIDE-1:0] x_r;
  logic [WIDE-1:0] y_r;
  logic [WIDE:0]   acc_r;
  logic [63:0]     root_r;

  logic [WIDE:0]   div_sh;
  logic [66:0]     sq_sh;
  logic [66:0]     sq_trial;

  assign div_sh   = {acc_r[WIDE-1:0], x_r[WIDE-1]};
  assign sq_sh    = {acc_r[64:0], x_r[WIDE-1:WIDE-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 7'd0);
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op_r   <= req.op;
      x_r    <= opnd_a;
      y_r    <= opnd_b;
      acc_r  <= '0;
      root_r <= '0;
      cnt    <= (req.op == OP_DIV) ? 7'd127 : 7'd63;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      case (op_r)
        OP_MUL: begin
          if (y_r[0]) acc_r <= {1'b0, acc_r[WIDE-1:0] + x_r};
          x_r <= {x_r[WIDE-2:0], 1'b0};
          y_r <= {1'b0, y_r[WIDE-1:1]};
        end
        OP_DIV: begin
          if (div_sh >= {1'b0, y_r}) begin
            acc_r <= div_sh - {1'b0, y_r};
            x_r   <= {x_r[WIDE-2:0], 1'b1};
          end else begin
            acc_r <= div_sh;
            x_r   <= {x_r[WIDE-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          if (sq_sh >= sq_trial) begin
            acc_r  <= {62'b0, sq_sh - sq_trial};
            root_r <= {root_r[62:0], 1'b1};
          end else begin
            acc_r  <= {62'b0, sq_sh};
            root_r <= {root_r[62:0], 1'b0};
          end
          x_r <= {x_r[WIDE-3:0], 2'b00};
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  always_comb begin
    case (op_r)
      OP_DIV:  result = x_r;
      OP_SQRT: result = {64'b0, root_r};
      default: result = acc_r[WIDE-1:0];
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* hdl/running_mean_deviation_stats.sv */
`timescale 1ns / 1ps
// Running count, mean, standard deviation, RMS and harmonic mean of a stream
// of 16-bit integer samples, in fixed point with FRAC_BITS fraction bits. Seed
// registers (count, mean, harmonic mean, deviation) load the running state
// when written; write them only while idle. For each sample, three 128-step
// divisions, six 64-step multiplies and two 64-step square roots run in
// sequence on one shared iterative unit, each launched once and advanced on
// its done. A zero sample or a zero harmonic denominator skips the last two
// multiplies and the last division; a negative variance skips the second
// root. in_ready is high only between samples; a finished result sits in the
// output register until taken, so the next sample may be accepted meanwhile.
`include "running_mean_deviation_stats_defines.svh"
module running_mean_deviation_stats
  import rmds_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     sample_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_WIDTH-1:0] value_count,
  output logic signed [47:0]     arithmetic_mean,
  output logic [46:0]            sigma_out,
  output logic [46:0]            quad_mean_out,
  output logic signed [47:0]     harmonic_mean_out,
  output logic                   zero_sample_flag
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [46:0]            M47     = '1;

  state_t state, state_next;

  logic [COUNT_WIDTH-1:0] count_reg;
  logic [47:0]            mean_reg;
  logic [46:0]            deviation_reg;
  logic [47:0]            harmonic_reg;

  logic [COUNT_WIDTH-1:0] n_r, w_r;
  logic [15:0]            xm_r;
  logic                   xn_r;
  logic                   diff_neg_r;
  logic [47:0]            mo_r;
  logic [47:0]            hm_r;
  logic                   hn_r;
  logic [47:0]            mnew_r;
  logic [WIDE-1:0]        acc_r;
  logic [WIDE-1:0]        ms_r;
  logic [WIDE-1:0]        t_r;
  logic [WIDE-1:0]        den_r;
  logic                   qn_r;
  logic [46:0]            rms_r;
  logic [46:0]            dev_r;
  logic [47:0]            harm_r;
  logic                   flag_r;
  logic                   launched;

  // accept-time values
  logic [COUNT_WIDTH-1:0] in_n;
  logic [15:0]            in_xm;
  logic signed [63:0]     bigx, msx, diff;
  logic [63:0]            diff_mag;
  logic [47:0]            mean_mag, harm_mag, mnew_mag;

  // harmonic denominator
  logic [WIDE-1:0] hw, den_c;
  logic            dn_c;

  arith_req_t      ar_req;
  arith_stat_t     ar_stat;
  logic [WIDE-1:0] ar_a, ar_b, ar_res;
  logic            load_out;
  logic [WIDE-1:0] q_cap;
  logic [47:0]     q_mag;

  rmds_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (ar_req),
    .opnd_a (ar_a),
    .opnd_b (ar_b),
    .stat   (ar_stat),
    .result (ar_res)
  );

  always_comb begin
    in_n     = (count_reg == CNT_MAX) ? count_reg : count_reg + COUNT_WIDTH'(1);
    in_xm    = sample_value[15] ? 16'(-sample_value) : sample_value;
    bigx     = {{48{sample_value[15]}}, sample_value} <<< FRAC_BITS;
    msx      = {{16{mean_reg[47]}}, mean_reg};
    diff     = bigx - msx;
    diff_mag = diff[63] ? 64'(-diff) : 64'(diff);
    mean_mag = mean_reg[47] ? 48'(-mean_reg) : mean_reg;
    harm_mag = harmonic_reg[47] ? 48'(-harmonic_reg) : harmonic_reg;
    mnew_mag = mnew_r[47] ? 48'(-mnew_r) : mnew_r;
  end

  always_comb begin
    hw = {{(WIDE-48){1'b0}}, hm_r};
    if (xn_r == hn_r) begin
      den_c = t_r + hw;
      dn_c  = xn_r;
    end else if (t_r >= hw) begin
      den_c = t_r - hw;
      dn_c  = xn_r;
    end else begin
      den_c = hw - t_r;
      dn_c  = hn_r;
    end
  end

  // harmonic quotient saturation
  always_comb begin
    q_cap = qn_r ? WIDE'(48'h8000_0000_0000) : WIDE'(48'h7FFF_FFFF_FFFF);
    q_mag = (ar_res > q_cap) ? q_cap[47:0] : ar_res[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ar_req.start = 1'b0;
    ar_req.op    = OP_MUL;
    ar_a = '0;
    ar_b = '0;
    load_out = 1'b0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        ar_req.op = OP_DIV;
        ar_a = WIDE'(acc_r[63:0]);
        ar_b = WIDE'(n_r);
      end
      S_DEV_SQ: begin
        ar_a = WIDE'(deviation_reg);
        ar_b = WIDE'(deviation_reg);
      end
      S_MEAN_SQ: begin
        ar_a = WIDE'(mo_r);
        ar_b = WIDE'(mo_r);
      end
      S_SCALE_W: begin
        ar_a = acc_r;
        ar_b = WIDE'(w_r);
      end
      S_MS_DIV: begin
        ar_req.op = OP_DIV;
        ar_a = acc_r;
        ar_b = WIDE'(n_r);
      end
      S_RMS_ROOT: begin
        ar_req.op = OP_SQRT;
        ar_a = ms_r;
      end
      S_NEW_SQ: begin
        ar_a = WIDE'(mnew_mag);
        ar_b = WIDE'(mnew_mag);
      end
      S_DEV_ROOT: begin
        ar_req.op = OP_SQRT;
        ar_a = ms_r - acc_r;
        if (ms_r < acc_r) state_next = S_HARM_T;
      end
      S_HARM_T: begin
        state_next = (xm_r == 16'd0) ? S_DONE : S_HARM_DEN;
      end
      S_HARM_DEN: begin
        state_next = (den_c == '0) ? S_DONE : S_HM_MUL;
      end
      S_HM_MUL: begin
        ar_a = WIDE'(hm_r);
        ar_b = WIDE'(xm_r);
      end
      S_HN_MUL: begin
        ar_a = acc_r;
        ar_b = WIDE'(n_r);
      end
      S_HARM_DIV: begin
        ar_req.op = OP_DIV;
        ar_a = acc_r;
        ar_b = den_r;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // arithmetic steps: launch once, advance on done
    if (state != S_IDLE && state != S_HARM_T && state != S_HARM_DEN &&
        state != S_DONE && !(state == S_DEV_ROOT && ms_r < acc_r)) begin
      ar_req.start = !launched;
      if (ar_stat.done) begin
        case (state)
          S_MEAN_DIV: state_next = S_DEV_SQ;
          S_DEV_SQ:   state_next = S_MEAN_SQ;
          S_MEAN_SQ:  state_next = S_SCALE_W;
          S_SCALE_W:  state_next = S_MS_DIV;
          S_MS_DIV:   state_next = S_RMS_ROOT;
          S_RMS_ROOT: state_next = S_NEW_SQ;
          S_NEW_SQ:   state_next = S_DEV_ROOT;
          S_DEV_ROOT: state_next = S_HARM_T;
          S_HM_MUL:   state_next = S_HN_MUL;
          S_HN_MUL:   state_next = S_HARM_DIV;
          S_HARM_DIV: state_next = S_DONE;
          default:    state_next = S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) launched <= 1'b0;
    else if (ar_stat.done) launched <= 1'b0;
    else if (ar_req.start) launched <= 1'b1;
  end

  // running state and seed writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg     <= COUNT_WIDTH'(1);
      mean_reg      <= '0;
      harmonic_reg  <= 48'(64'd1 << FRAC_BITS);
      deviation_reg <= '0;
    end else if (load_out) begin
      count_reg     <= n_r;
      mean_reg      <= mnew_r;
      deviation_reg <= dev_r;
      harmonic_reg  <= harm_r;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED_COUNT:     count_reg     <= cfg_data[COUNT_WIDTH-1:0];
        REG_SEED_MEAN:      mean_reg      <= cfg_data;
        REG_SEED_HARMONIC:  harmonic_reg  <= cfg_data;
        REG_SEED_DEVIATION: deviation_reg <= cfg_data[46:0];
        default:            count_reg     <= count_reg;
      endcase
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      n_r        <= in_n;
      w_r        <= in_n - COUNT_WIDTH'(1);
      xm_r       <= in_xm;
      xn_r       <= sample_value[15];
      diff_neg_r <= diff[63];
      acc_r      <= WIDE'(diff_mag);
      mo_r       <= mean_mag;
      hm_r       <= harm_mag;
      hn_r       <= harmonic_reg[47];
      harm_r     <= harmonic_reg;
      flag_r     <= 1'b0;
    end else if (state == S_DEV_ROOT && ms_r < acc_r) begin
      dev_r <= '0;
    end else if (state == S_HARM_T) begin
      if (xm_r == 16'd0) flag_r <= 1'b1;
      t_r <= WIDE'(48'(w_r) * 48'(xm_r)) << FRAC_BITS;
    end else if (state == S_HARM_DEN) begin
      den_r <= den_c;
      qn_r  <= (hn_r != xn_r) != dn_c;
    end else if (ar_stat.done) begin
      case (state)
        S_MEAN_DIV: mnew_r <= diff_neg_r ? mean_reg - ar_res[47:0]
                                         : mean_reg + ar_res[47:0];
        S_DEV_SQ:   acc_r  <= ar_res;
        S_MEAN_SQ:  acc_r  <= acc_r + ar_res;
        S_SCALE_W:  acc_r  <= ar_res +
                              (WIDE'(32'(xm_r) * 32'(xm_r)) << (2 * FRAC_BITS));
        S_MS_DIV:   ms_r   <= ar_res;
        S_RMS_ROOT: rms_r  <= (ar_res > WIDE'(M47)) ? M47 : ar_res[46:0];
        S_NEW_SQ:   acc_r  <= ar_res;
        S_DEV_ROOT: dev_r  <= (ar_res > WIDE'(M47)) ? M47 : ar_res[46:0];
        S_HM_MUL:   acc_r  <= ar_res;
        S_HN_MUL:   acc_r  <= ar_res << FRAC_BITS;
        S_HARM_DIV: harm_r <= qn_r ? 48'(-q_mag) : q_mag;
        default:    acc_r  <= acc_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_count       <= n_r;
      arithmetic_mean   <= mnew_r;
      sigma_out         <= dev_r;
      quad_mean_out     <= rms_r;
      harmonic_mean_out <= harm_r;
      zero_sample_flag  <= flag_r;
    end
  end

  `RMDS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `RMDS_ASSERT_NXT(a_result_held, out_valid && !out_ready,
                   out_valid && $stable(arithmetic_mean) && $stable(value_count))
  `RMDS_ASSERT_IMP(a_start_only_when_free, ar_req.start, !ar_stat.busy && !ar_stat.done)

endmodule
